// ===== rtl/tfvc_pkg.sv =====
`timescale 1ns / 1ps

package tfvc_pkg;

    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned TOGGLE_W = 8;
    localparam int unsigned DEB_W    = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_ON_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_OFF_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_UP_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_HOLD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_PERIOD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATER_HOLD    = 3'd7;

    // reset values
    localparam logic                RST_RUN_ENABLE     = 1'b1;
    localparam logic [WEIGHT_W-1:0] RST_FULL_ON_LEVEL  = 16'd1000;
    localparam logic [WEIGHT_W-1:0] RST_FULL_OFF_LEVEL = 16'd900;
    localparam logic [WEIGHT_W-1:0] RST_TOP_UP_LEVEL   = 16'd1700;
    localparam logic [TIMER_W-1:0]  RST_FILL_TIMEOUT   = 16'd12000;
    localparam logic [TIMER_W-1:0]  RST_VALVE_HOLD     = 16'd20;
    localparam logic [TOGGLE_W-1:0] RST_TOGGLE_PERIOD  = 8'd50;
    localparam logic [TIMER_W-1:0]  RST_HEATER_HOLD    = 16'd700;

    localparam logic OP_FAST = 1'b0;
    localparam logic OP_SLOW = 1'b1;

    // hold timer slots
    localparam int unsigned NUM_TIMERS = 3;
    localparam int unsigned T_HEATER = 0;
    localparam int unsigned T_VALVE  = 1;
    localparam int unsigned T_FULL   = 2;

    localparam logic [DEB_W-1:0] DEB_MAX = 2'd3;

    typedef struct packed {
        logic                run_enable;
        logic [WEIGHT_W-1:0] full_on_level;
        logic [WEIGHT_W-1:0] full_off_level;
        logic [WEIGHT_W-1:0] top_up_level;
        logic [TIMER_W-1:0]  fill_timeout;
        logic [TIMER_W-1:0]  valve_hold;
        logic [TOGGLE_W-1:0] toggle_period;
        logic [TIMER_W-1:0]  heater_hold;
    } cfg_t;

    typedef struct packed {
        logic                operation;
        logic                sensor_one_level;
        logic                sensor_two_level;
        logic [WEIGHT_W-1:0] weight;
        logic                intake_active;
    } in_t;

    typedef struct packed {
        logic heater_on;
        logic fill_valve_on;
        logic full_signal_on;
        logic sensor_one_detect;
        logic sensor_two_detect;
        logic tank_full;
        logic fill_error;
    } out_t;

endpackage

// ===== rtl/tfvc_cfg_regs.sv =====
`timescale 1ns / 1ps

module tfvc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tfvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfvc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output tfvc_pkg::cfg_t                     cfg
);
    import tfvc_pkg::*;

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_enable     <= RST_RUN_ENABLE;
            cfg_reg.full_on_level  <= RST_FULL_ON_LEVEL;
            cfg_reg.full_off_level <= RST_FULL_OFF_LEVEL;
            cfg_reg.top_up_level   <= RST_TOP_UP_LEVEL;
            cfg_reg.fill_timeout   <= RST_FILL_TIMEOUT;
            cfg_reg.valve_hold     <= RST_VALVE_HOLD;
            cfg_reg.toggle_period  <= RST_TOGGLE_PERIOD;
            cfg_reg.heater_hold    <= RST_HEATER_HOLD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RUN_ENABLE:     cfg_reg.run_enable     <= cfg_wdata[0];
                CFG_FULL_ON_LEVEL:  cfg_reg.full_on_level  <= cfg_wdata[WEIGHT_W-1:0];
                CFG_FULL_OFF_LEVEL: cfg_reg.full_off_level <= cfg_wdata[WEIGHT_W-1:0];
                CFG_TOP_UP_LEVEL:   cfg_reg.top_up_level   <= cfg_wdata[WEIGHT_W-1:0];
                CFG_FILL_TIMEOUT:   cfg_reg.fill_timeout   <= cfg_wdata[TIMER_W-1:0];
                CFG_VALVE_HOLD:     cfg_reg.valve_hold     <= cfg_wdata[TIMER_W-1:0];
                CFG_TOGGLE_PERIOD:  cfg_reg.toggle_period  <= cfg_wdata[TOGGLE_W-1:0];
                CFG_HEATER_HOLD:    cfg_reg.heater_hold    <= cfg_wdata[TIMER_W-1:0];
            endcase
        end
    end

endmodule

// ===== rtl/tank_fill_valve_controller_core.sv =====
`timescale 1ns / 1ps

// Tank fill controller core. Each tick transaction (fast or slow) is applied to the
// internal state in the cycle it is accepted and yields one result transaction from
// the output register in the next cycle. Throughput is one tick per clock; the output
// register holds a result while the sink stalls and a new tick is taken in the same
// cycle the held result leaves. Config writes take effect at the next clock edge and
// are to be issued only while no tick is in flight.
module tank_fill_valve_controller_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tfvc_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tfvc_pkg::out_t                     m_data,
    input  logic                               cfg_wr_en,
    input  logic [tfvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfvc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tfvc_pkg::*;

    cfg_t cfg;

    tfvc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic [DEB_W-1:0]    deb_cnt_reg   [2];
    logic [DEB_W-1:0]    deb_cnt_next  [2];
    logic                detect_reg    [2];
    logic                detect_next   [2];
    logic [TIMER_W-1:0]  timer_reg     [NUM_TIMERS];
    logic [TIMER_W-1:0]  timer_next    [NUM_TIMERS];
    logic                level_reg     [NUM_TIMERS];
    logic                level_next    [NUM_TIMERS];
    logic [TOGGLE_W-1:0] toggle_cnt_reg, toggle_cnt_next;
    logic                toggle_phase_reg, toggle_phase_next;
    logic                full_reg, full_next;
    logic [TIMER_W-1:0]  elapsed_reg, elapsed_next;
    logic                error_reg, error_next;
    logic                m_valid_reg;
    out_t                m_data_reg, m_data_next;
    logic                pins [2];
    logic                accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pins[0] = s_data.sensor_one_level;
    assign pins[1] = s_data.sensor_two_level;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            deb_cnt_next[k] = deb_cnt_reg[k];
            detect_next[k]  = detect_reg[k];
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
            timer_next[i] = timer_reg[i];
            level_next[i] = level_reg[i];
        end
        toggle_cnt_next   = toggle_cnt_reg;
        toggle_phase_next = toggle_phase_reg;
        full_next         = full_reg;
        elapsed_next      = elapsed_reg;
        error_next        = error_reg;

        if (s_data.operation == OP_FAST) begin
            // active-low pins; detection on the fourth straight low tick
            for (int k = 0; k < 2; k++) begin
                if (!pins[k]) begin
                    detect_next[k] = (deb_cnt_reg[k] == DEB_MAX);
                    if (deb_cnt_reg[k] != DEB_MAX)
                        deb_cnt_next[k] = deb_cnt_reg[k] + 1'b1;
                end else begin
                    deb_cnt_next[k] = '0;
                    detect_next[k]  = 1'b0;
                end
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                level_next[i] = (timer_reg[i] != '0);
                if (timer_reg[i] != '0)
                    timer_next[i] = timer_reg[i] - 1'b1;
            end
        end else begin
            toggle_cnt_next = toggle_cnt_reg + 1'b1;
            if (toggle_cnt_reg > cfg.toggle_period) begin
                toggle_cnt_next   = '0;
                toggle_phase_next = !toggle_phase_reg;
                timer_next[T_HEATER] = toggle_phase_reg ? cfg.heater_hold : '0;
            end

            if (cfg.run_enable) begin
                if (!full_reg)
                    full_next = (s_data.weight > cfg.full_on_level);
                else
                    full_next = !(s_data.weight < cfg.full_off_level);

                priority if (full_next) begin
                    timer_next[T_FULL] = cfg.valve_hold;
                    elapsed_next       = '0;
                    error_next         = 1'b0;
                    if (!s_data.intake_active && s_data.weight < cfg.top_up_level)
                        timer_next[T_VALVE] = cfg.valve_hold;
                end else if (error_reg) begin
                    timer_next[T_VALVE] = '0;
                end else if (!s_data.intake_active) begin
                    if (elapsed_reg >= cfg.fill_timeout) begin
                        elapsed_next        = '0;
                        error_next          = 1'b1;
                        timer_next[T_VALVE] = '0;
                    end else begin
                        elapsed_next        = elapsed_reg + 1'b1;
                        timer_next[T_VALVE] = cfg.valve_hold;
                    end
                end else begin
                    elapsed_next        = '0;
                    timer_next[T_VALVE] = '0;
                end
            end
        end

        m_data_next.heater_on         = level_next[T_HEATER];
        m_data_next.fill_valve_on     = level_next[T_VALVE];
        m_data_next.full_signal_on    = level_next[T_FULL];
        m_data_next.sensor_one_detect = detect_next[0];
        m_data_next.sensor_two_detect = detect_next[1];
        m_data_next.tank_full         = full_next;
        m_data_next.fill_error        = error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                deb_cnt_reg[k] <= '0;
                detect_reg[k]  <= 1'b0;
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                timer_reg[i] <= '0;
                level_reg[i] <= 1'b0;
            end
            toggle_cnt_reg   <= '0;
            toggle_phase_reg <= 1'b0;
            full_reg         <= 1'b0;
            elapsed_reg      <= '0;
            error_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                for (int k = 0; k < 2; k++) begin
                    deb_cnt_reg[k] <= deb_cnt_next[k];
                    detect_reg[k]  <= detect_next[k];
                end
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    timer_reg[i] <= timer_next[i];
                    level_reg[i] <= level_next[i];
                end
                toggle_cnt_reg   <= toggle_cnt_next;
                toggle_phase_reg <= toggle_phase_next;
                full_reg         <= full_next;
                elapsed_reg      <= elapsed_next;
                error_reg        <= error_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept)
            m_data_reg <= m_data_next;
    end

endmodule
